[rtl/core/savitzky_golay_smoother_core_defines.svh]
// assertion helpers shared by the smoother rtl
`ifndef SAVITZKY_GOLAY_SMOOTHER_CORE_DEFINES_SVH
`define SAVITZKY_GOLAY_SMOOTHER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sgs_pkg.sv]
package sgs_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned CFG_W    = 5;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_SHORT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

[rtl/core/sgs_ram.sv]
module sgs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sgs_mac.sv]
`include "savitzky_golay_smoother_core_defines.svh"

module sgs_mac #(
  parameter int unsigned MAX_WIN        = 33,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sgs_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [sgs_pkg::COEF_W-1:0]    coef_i,
  input  logic signed [sgs_pkg::SAMPLE_W-1:0]  samp_i,
  output logic                                 busy_o,
  output logic signed [sgs_pkg::SAMPLE_W-1:0]  result_o,
  output logic                                 sat_o
);

  localparam int unsigned PROD_W = sgs_pkg::SAMPLE_W + sgs_pkg::COEF_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_WIN);
  localparam int unsigned RND_W  = ACC_W + 1;
  localparam logic signed [RND_W-1:0] HALF_LSB = RND_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] OUT_MAX  = RND_W'((1 << (sgs_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] OUT_MIN  = -(RND_W'(1) <<< (sgs_pkg::SAMPLE_W - 1));

  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [RND_W-1:0]  rnd, quo;

  // read data valid, then product valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(coef_i) * PROD_W'(samp_i);
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, floor shift, saturate
  always_comb begin
    rnd   = RND_W'(acc_q) + HALF_LSB;
    quo   = rnd >>> COEF_FRAC_BITS;
    sat_o = 1'b0;
    result_o = sgs_pkg::SAMPLE_W'(quo);
    if (quo > OUT_MAX) begin
      result_o = sgs_pkg::SAMPLE_W'(OUT_MAX);
      sat_o    = 1'b1;
    end else if (quo < OUT_MIN) begin
      result_o = sgs_pkg::SAMPLE_W'(OUT_MIN);
      sat_o    = 1'b1;
    end
  end

  assign busy_o = v1_q | v2_q;

  `SGS_ASSERT_NOW(a_clear_idle, ctrl_i.clear, !busy_o, "mac cleared while taps in flight")
  `SGS_ASSERT_NOW(a_clear_no_issue, ctrl_i.clear, !(v2_q && ctrl_i.issue && v1_q), "overlap")
  `SGS_ASSERT_NEXT(a_pipe_moves, v1_q, v2_q, "product stage lost a tap")

endmodule

[rtl/core/savitzky_golay_smoother_core.sv]
// channel  | direction | word
// ---------+-----------+-----------------------------------------------------
// in       | input     | op, sample, end_of_record, cf_row, coef_col, coef_value
// out      | output    | smoothed, status, last_of_run
// cfg      | input     | half_width (write only)
//
// each result row: 2*hw+1 taps issued through one shared multiply-accumulate,
// then the ram read, product and accumulate registers drain, then the output word
// the first row of a full window is started by the sample accepted in idle
// a coefficient item or a filling sample leaves the block in idle; in_ready_o is high only in idle
// a stalled output holds the block until the word is taken
// async active-low reset; window entries are read only after the current record wrote them
`include "savitzky_golay_smoother_core_defines.svh"

module savitzky_golay_smoother_core #(
  parameter int unsigned MAX_HALF_WIDTH = 16,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config
  input  logic                                cfg_we_i,
  input  logic [sgs_pkg::CFG_W-1:0]           cfg_wdata_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic signed [sgs_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                end_of_record_i,
  input  logic [4:0]                          cf_row_i,
  input  logic [5:0]                          coef_col_i,
  input  logic signed [sgs_pkg::COEF_W-1:0]   coef_value_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sgs_pkg::SAMPLE_W-1:0] smoothed_o,
  output logic [1:0]                          status_o,
  output logic                                last_of_run_o
);

  localparam int unsigned MAX_WIN  = 2 * MAX_HALF_WIDTH + 1;
  localparam int unsigned WI_W     = $clog2(MAX_WIN);
  localparam int unsigned HW_W     = $clog2(MAX_HALF_WIDTH + 1);
  localparam int unsigned FC_W     = $clog2(MAX_WIN + 1);
  localparam int unsigned CT_DEPTH = (MAX_HALF_WIDTH + 1) * MAX_WIN;
  localparam int unsigned CA_W     = $clog2(CT_DEPTH);

  sgs_pkg::state_e state_q, state_d;

  logic [sgs_pkg::CFG_W-1:0] hw_cfg_q, hw_cfg_d;
  logic [FC_W-1:0]           fill_q, fill_d;
  logic [WI_W-1:0]           wp_q, wp_d;      // next window slot to write
  logic [WI_W-1:0]           base_q, base_d;  // oldest sample of the window
  logic [WI_W-1:0]           rp_q, rp_d;      // window read pointer
  logic [WI_W-1:0]           tap_q, tap_d;
  logic [WI_W-1:0]           row_q, row_d;
  logic [WI_W-1:0]           last_row_q, last_row_d;

  logic signed [sgs_pkg::SAMPLE_W-1:0] smoothed_q, smoothed_d;
  sgs_pkg::status_e                    status_q, status_d;
  logic                                last_q, last_d;

  // effective half width, clamped into 1..MAX_HALF_WIDTH
  logic [HW_W-1:0] hw_eff;
  logic [WI_W-1:0] two_hw;
  logic [FC_W-1:0] win_len;

  always_comb begin
    if (hw_cfg_q == '0) begin
      hw_eff = HW_W'(1);
    end else if (32'(hw_cfg_q) > MAX_HALF_WIDTH) begin
      hw_eff = HW_W'(MAX_HALF_WIDTH);
    end else begin
      hw_eff = HW_W'(hw_cfg_q);
    end
  end

  assign two_hw  = WI_W'({hw_eff, 1'b0});
  assign win_len = FC_W'(two_hw) + FC_W'(1);

  logic accept_in;
  assign accept_in = in_valid_i & in_ready_o;

  // window ring
  logic [WI_W-1:0] wp_inc, rp_inc;
  logic [WI_W:0]   base_sum;
  logic [WI_W-1:0] base_new;

  assign wp_inc   = (wp_q == WI_W'(MAX_WIN - 1)) ? '0 : wp_q + WI_W'(1);
  assign rp_inc   = (rp_q == WI_W'(MAX_WIN - 1)) ? '0 : rp_q + WI_W'(1);
  assign base_sum = {1'b0, wp_q} + (WI_W + 1)'(MAX_WIN) - {1'b0, two_hw};
  assign base_new = (base_sum >= (WI_W + 1)'(MAX_WIN)) ?
                    WI_W'(base_sum - (WI_W + 1)'(MAX_WIN)) : WI_W'(base_sum);

  logic win_we;
  logic signed [sgs_pkg::SAMPLE_W-1:0] win_rdata;

  assign win_we = accept_in && (op_i == sgs_pkg::OP_SAMPLE);

  sgs_ram #(
    .WIDTH (sgs_pkg::SAMPLE_W),
    .DEPTH (MAX_WIN)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .raddr_i (rp_q),
    .rdata_o (win_rdata)
  );

  // coefficient table, rows past hw read mirrored
  logic            coef_we;
  logic [CA_W-1:0] coef_waddr, coef_raddr;
  logic            mirrored;
  logic [WI_W-1:0] row_eff, col_eff;
  logic signed [sgs_pkg::COEF_W-1:0] coef_rdata;

  assign coef_we = accept_in && (op_i == sgs_pkg::OP_COEF)
                   && (32'(cf_row_i) <= MAX_HALF_WIDTH)
                   && (32'(coef_col_i) < MAX_WIN);
  assign coef_waddr = CA_W'(cf_row_i) * CA_W'(MAX_WIN) + CA_W'(coef_col_i);

  assign mirrored   = row_q > WI_W'(hw_eff);
  assign row_eff    = mirrored ? two_hw - row_q : row_q;
  assign col_eff    = mirrored ? two_hw - tap_q : tap_q;
  assign coef_raddr = CA_W'(row_eff) * CA_W'(MAX_WIN) + CA_W'(col_eff);

  sgs_ram #(
    .WIDTH (sgs_pkg::COEF_W),
    .DEPTH (CT_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_value_i),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // shared multiply-accumulate
  sgs_pkg::mac_ctrl_t mac_ctrl;
  logic mac_busy, mac_sat;
  logic signed [sgs_pkg::SAMPLE_W-1:0] mac_result;

  sgs_mac #(
    .MAX_WIN        (MAX_WIN),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_rdata),
    .samp_i   (win_rdata),
    .busy_o   (mac_busy),
    .result_o (mac_result),
    .sat_o    (mac_sat)
  );

  // sequencer
  logic [FC_W-1:0] fill_inc;
  assign fill_inc = (fill_q < win_len) ? fill_q + FC_W'(1) : win_len;

  always_comb begin
    state_d    = state_q;
    hw_cfg_d   = hw_cfg_q;
    fill_d     = fill_q;
    wp_d       = wp_q;
    base_d     = base_q;
    rp_d       = rp_q;
    tap_d      = tap_q;
    row_d      = row_q;
    last_row_d = last_row_q;
    smoothed_d = smoothed_q;
    status_d   = status_q;
    last_d     = last_q;
    mac_ctrl   = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      sgs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && (op_i == sgs_pkg::OP_SAMPLE)) begin
          wp_d   = wp_inc;
          fill_d = end_of_record_i ? '0 : fill_inc;
          if (fill_inc == win_len) begin
            // window full: left edge rows on first fill, then centre, right edge at end
            row_d      = (fill_q < win_len) ? '0 : WI_W'(hw_eff);
            last_row_d = end_of_record_i ? two_hw : WI_W'(hw_eff);
            base_d     = base_new;
            rp_d       = base_new;
            tap_d      = '0;
            mac_ctrl.clear = 1'b1;
            state_d    = sgs_pkg::ST_ISSUE;
          end else if (end_of_record_i) begin
            // record shorter than the window
            smoothed_d = '0;
            status_d   = sgs_pkg::STATUS_SHORT;
            last_d     = 1'b1;
            state_d    = sgs_pkg::ST_OUT;
          end
        end
      end
      sgs_pkg::ST_ISSUE: begin
        mac_ctrl.issue = 1'b1;
        tap_d = tap_q + WI_W'(1);
        rp_d  = rp_inc;
        if (tap_q == two_hw) begin
          state_d = sgs_pkg::ST_DRAIN;
        end
      end
      sgs_pkg::ST_DRAIN: begin
        if (!mac_busy) begin
          smoothed_d = mac_result;
          status_d   = mac_sat ? sgs_pkg::STATUS_SAT : sgs_pkg::STATUS_OK;
          last_d     = (row_q == last_row_q);
          state_d    = sgs_pkg::ST_OUT;
        end
      end
      sgs_pkg::ST_OUT: begin
        if (out_ready_i) begin
          if (last_q) begin
            state_d = sgs_pkg::ST_IDLE;
          end else begin
            row_d = row_q + WI_W'(1);
            tap_d = '0;
            rp_d  = base_q;
            mac_ctrl.clear = 1'b1;
            state_d = sgs_pkg::ST_ISSUE;
          end
        end
      end
      default: state_d = sgs_pkg::ST_IDLE;
    endcase

    // register write drops the open record
    if (cfg_we_i) begin
      hw_cfg_d = cfg_wdata_i;
      fill_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sgs_pkg::ST_IDLE;
      hw_cfg_q <= sgs_pkg::CFG_W'(2);
      fill_q   <= '0;
      wp_q     <= '0;
    end else begin
      state_q  <= state_d;
      hw_cfg_q <= hw_cfg_d;
      fill_q   <= fill_d;
      wp_q     <= wp_d;
    end
  end

  // payload and sequencing registers, no reset needed
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    rp_q       <= rp_d;
    tap_q      <= tap_d;
    row_q      <= row_d;
    last_row_q <= last_row_d;
    smoothed_q <= smoothed_d;
    status_q   <= status_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = (state_q == sgs_pkg::ST_OUT);
  assign smoothed_o    = smoothed_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

  `SGS_ASSERT_NOW(a_short_is_last,
    out_valid_o && (status_o == sgs_pkg::STATUS_SHORT), last_of_run_o && (smoothed_o == '0),
    "short record word must be a single zero word")
  `SGS_ASSERT_NOW(a_ready_mac_quiet, in_ready_o, !mac_busy, "input taken while mac busy")
  `SGS_ASSERT_NEXT(a_last_frees, out_valid_o && out_ready_i && last_of_run_o, in_ready_o,
    "block not free after last word")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_HW   = 16;
  localparam int WIN_MAX  = 2 * MAX_HW + 1;
  localparam int TBL_HW   = 7;
  localparam int FRAC     = 14;
  localparam int IDLE_CAP = 3000;
  localparam logic signed [sgs_pkg::SAMPLE_W-1:0] S_MAX = 24'sh7fffff;
  localparam logic signed [sgs_pkg::SAMPLE_W-1:0] S_MIN = -24'sh800000;
  localparam logic signed [sgs_pkg::COEF_W-1:0]   C_MAX = 18'sh1ffff;
  localparam logic signed [sgs_pkg::COEF_W-1:0]   C_MIN = -18'sh20000;

  typedef struct {
    logic signed [sgs_pkg::SAMPLE_W-1:0] smoothed;
    sgs_pkg::status_e                    status;
    logic                                last;
  } smooth_result_t;

  // predicts the smoothed words and checks the ones that come out
  class smoothing_scoreboard;
    logic signed [sgs_pkg::SAMPLE_W-1:0] window [WIN_MAX];
    logic signed [sgs_pkg::COEF_W-1:0]   coefs [MAX_HW+1][WIN_MAX];
    int                                  fill;
    logic [sgs_pkg::CFG_W-1:0]           hw_reg;
    int                                  errors;
    smooth_result_t                      pending_results [$];

    function new();
      foreach (window[i]) window[i] = '0;
      foreach (coefs[r, c]) coefs[r][c] = '0;
      fill = 0;
      hw_reg = sgs_pkg::CFG_W'(2);
      errors = 0;
    endfunction

    function void set_half_width(logic [sgs_pkg::CFG_W-1:0] v);
      hw_reg = v;
      fill = 0;
    endfunction

    function int active_hw();
      if (hw_reg < 1) return 1;
      if (hw_reg > MAX_HW) return MAX_HW;
      return int'(hw_reg);
    endfunction

    function void push_row(int r, int hw);
      int w;
      int rr;
      int jj;
      longint acc;
      longint q;
      smooth_result_t res;
      w = 2 * hw + 1;
      acc = 0;
      for (int j = 0; j < w; j++) begin
        rr = r;
        jj = j;
        // rows past the centre read mirrored
        if (r > hw) begin
          rr = w - 1 - r;
          jj = w - 1 - j;
        end
        acc += longint'(coefs[rr][jj]) * longint'(window[w-1-j]);
      end
      acc += longint'(1) <<< (FRAC - 1);
      q = acc >>> FRAC;
      res.status = sgs_pkg::STATUS_OK;
      if (q > longint'(S_MAX)) begin
        q = S_MAX;
        res.status = sgs_pkg::STATUS_SAT;
      end
      if (q < longint'(S_MIN)) begin
        q = S_MIN;
        res.status = sgs_pkg::STATUS_SAT;
      end
      res.smoothed = q[sgs_pkg::SAMPLE_W-1:0];
      res.last = 1'b0;
      pending_results.push_back(res);
    endfunction

    function void note_word(logic op, logic signed [sgs_pkg::SAMPLE_W-1:0] sample, logic eor,
                            logic [4:0] row, logic [5:0] col,
                            logic signed [sgs_pkg::COEF_W-1:0] val);
      int hw;
      int w;
      int prev;
      int n0;
      smooth_result_t res;
      if (op == sgs_pkg::OP_COEF) begin
        if (row <= MAX_HW && col < WIN_MAX) coefs[row][col] = val;
        return;
      end
      hw = active_hw();
      w = 2 * hw + 1;
      for (int i = WIN_MAX - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = sample;
      prev = fill;
      fill = (fill < w) ? fill + 1 : w;
      n0 = pending_results.size();
      if (fill >= w) begin
        if (prev < w) for (int r = 0; r < hw; r++) push_row(r, hw);
        push_row(hw, hw);
        if (eor) for (int r = hw + 1; r < w; r++) push_row(r, hw);
      end else if (eor) begin
        res.smoothed = '0;
        res.status = sgs_pkg::STATUS_SHORT;
        res.last = 1'b0;
        pending_results.push_back(res);
      end
      if (eor) fill = 0;
      if (pending_results.size() > n0) begin
        res = pending_results.pop_back();
        res.last = 1'b1;
        pending_results.push_back(res);
      end
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic signed [sgs_pkg::SAMPLE_W-1:0] smoothed, logic [1:0] status,
                    logic last);
      smooth_result_t exp_r;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word smoothed=%0d status=%0d", smoothed, status));
        return;
      end
      exp_r = pending_results.pop_front();
      if (smoothed !== exp_r.smoothed)
        report($sformatf("smoothed %0d, want %0d", smoothed, exp_r.smoothed));
      if (status !== exp_r.status)
        report($sformatf("status %0d, want %0d", status, exp_r.status));
      if (last !== exp_r.last)
        report($sformatf("last_of_run %0b, want %0b", last, exp_r.last));
    endtask
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [sgs_pkg::CFG_W-1:0]           cfg_wdata_i;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic                                op_i;
  logic signed [sgs_pkg::SAMPLE_W-1:0] sample_i;
  logic                                end_of_record_i;
  logic [4:0]                          cf_row_i;
  logic [5:0]                          coef_col_i;
  logic signed [sgs_pkg::COEF_W-1:0]   coef_value_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [sgs_pkg::SAMPLE_W-1:0] smoothed_o;
  logic [1:0]                          status_o;
  logic                                last_of_run_o;

  smoothing_scoreboard sb;
  bit calm;       // no idling on either side while set
  int idle_cycles = 0;
  int n_items;

  savitzky_golay_smoother_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .sample_i       (sample_i),
    .end_of_record_i(end_of_record_i),
    .cf_row_i       (cf_row_i),
    .coef_col_i     (coef_col_i),
    .coef_value_i   (coef_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .smoothed_o     (smoothed_o),
    .status_o       (status_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // mostly short gaps, now and then a long one
  function int gap_len();
    int pick;
    if (calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // extremes, small values and full-range noise
  function logic signed [sgs_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return $signed(24'($urandom_range(0, 400))) - 24'sd200;
      default: return 24'($urandom);
    endcase
  endfunction

  // coefficients kept mostly small so that unsaturated results show up often
  function logic signed [sgs_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3: return 18'($urandom);
      default: return $signed(18'($urandom_range(0, 3000))) - 18'sd1500;
    endcase
  endfunction

  // result side: random stalls, ready changes at the falling edge
  initial begin
    int stall;
    out_ready_i = 1'b0;
    forever begin
      stall = gap_len();
      repeat (stall) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk_i);
        out_ready_i = 1'b1;
      end
    end
  end

  // compare every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && sb != null && out_valid_o && out_ready_i)
      sb.check_word(smoothed_o, status_o, last_of_run_o);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_CAP) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input word, held until accepted, then an optional gap
  task send_word(logic op, logic signed [sgs_pkg::SAMPLE_W-1:0] sample, logic eor,
                 logic [4:0] row, logic [5:0] col, logic signed [sgs_pkg::COEF_W-1:0] val);
    int gap;
    @(negedge clk_i);
    op_i = op;
    sample_i = sample;
    end_of_record_i = eor;
    cf_row_i = row;
    coef_col_i = col;
    coef_value_i = val;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, sample, eor, row, col, val);
    n_items++;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // unused coefficient fields carry noise
  task send_sample(logic signed [sgs_pkg::SAMPLE_W-1:0] s, logic eor);
    send_word(sgs_pkg::OP_SAMPLE, s, eor, 5'($urandom), 6'($urandom), 18'($urandom));
  endtask

  // sample and end-of-record bits are don't-care on a coefficient write
  task send_coef(logic [4:0] row, logic [5:0] col, logic signed [sgs_pkg::COEF_W-1:0] val);
    send_word(sgs_pkg::OP_COEF, 24'($urandom), 1'($urandom), row, col, val);
  endtask

  task wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // register write only with the block idle, once all pending results are in
  task write_half_width(logic [sgs_pkg::CFG_W-1:0] v);
    wait_drained();
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    sb.set_half_width(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one record of len samples, coefficient words sometimes mixed in
  task send_record(int len, bit close);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_coef(5'($urandom_range(0, MAX_HW)), 6'($urandom_range(0, WIN_MAX - 1)),
                  rand_coef());
      send_sample(rand_sample(), close && (i == len - 1));
    end
  endtask

  initial begin
    logic [sgs_pkg::CFG_W-1:0] hw_plan [$];
    int hw;
    int w;
    int budget;
    int pick;
    sb = new();
    calm = 1'b1;
    n_items = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    op_i = sgs_pkg::OP_SAMPLE;
    sample_i = '0;
    end_of_record_i = 1'b0;
    cf_row_i = '0;
    coef_col_i = '0;
    coef_value_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every coefficient that the half widths below can read
    for (int r = 0; r <= TBL_HW; r++)
      for (int c = 0; c <= 2 * TBL_HW; c++)
        send_coef(5'(r), 6'(c), rand_coef());

    // directed, half width 2 out of reset
    calm = 1'b0;
    send_coef(5'd17, 6'd0, C_MAX);        // row past the table, ignored
    send_coef(5'd31, 6'd5, C_MIN);
    send_coef(5'd0, 6'd33, C_MAX);        // column past the window, ignored
    send_coef(5'd0, 6'd63, C_MIN);
    send_coef(5'd0, 6'd0, C_MIN);
    send_coef(5'd1, 6'd4, C_MAX);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b1);             // exactly one window
    send_sample(S_MIN, 1'b1);             // record of one sample
    for (int i = 0; i < 4; i++) send_sample(rand_sample(), i == 3);  // one short
    for (int i = 0; i < 6; i++) send_sample(S_MAX, i == 5);         // saturating

    // phases over several half widths, zero among them
    hw_plan = '{5'd1, 5'd0, 5'd3, 5'd7, 5'd2, 5'($urandom_range(1, TBL_HW))};
    foreach (hw_plan[p]) begin
      write_half_width(hw_plan[p]);
      calm = (p % 3 == 2);
      hw = sb.active_hw();
      w = 2 * hw + 1;
      budget = n_items + 35;
      while (n_items < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_record($urandom_range(1, w - 1), 1'b1);
        end else if (pick < 18) begin
          send_coef(5'($urandom), 6'($urandom), rand_coef());
        end else if (pick < 22) begin
          wait_drained();                 // hold off until all results are in
        end else begin
          send_record(w + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0), 1'b1);
        end
      end
      // leave a record open now and then; the next register write, if any, drops it
      if (p % 2 == 1) send_record($urandom_range(1, w + 3), 1'b0);
    end

    wait_drained();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/sgs_pkg.sv
rtl/core/sgs_ram.sv
rtl/core/sgs_mac.sv
rtl/core/savitzky_golay_smoother_core.sv
tb/testbench.sv
